>>> hw/rtl/triangle_contour_segments_assert.svh
// Assertion macros used by the checker file.
`ifndef TRIANGLE_CONTOUR_SEGMENTS_ASSERT_SVH
`define TRIANGLE_CONTOUR_SEGMENTS_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define TCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tcs_pkg.sv
package tcs_pkg;

	// Active contour levels supported by the datapath
	localparam int MAX_LEVELS = 4;
	localparam int LVL_W      = 2;

	// Divider: quotient bits, stages and steps per stage
	localparam int QUO_W      = 16;
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEPS  = QUO_W / DIV_STAGES;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LEVEL_0,
		REG_LEVEL_1,
		REG_LEVEL_2,
		REG_LEVEL_3,
		REG_NUM_LEVELS,
		REG_GRID_SCALE,
		REG_X_OFFSET,
		REG_Y_OFFSET
	} reg_idx_t;

	// Job sideband carried alongside the divider
	typedef struct packed {
		logic             tri_idx;
		logic [LVL_W-1:0] lv;
		logic             eoc;
		logic             hits2;
		logic [3:0]       ends0;
		logic [3:0]       ends1;
		logic [23:0]      sc;
		logic [23:0]      sr;
	} meta_t;

	// Side endpoints as {dj1, dk1, dj2, dk2}
	function automatic logic [3:0] side_ends(input logic tri_idx, input logic [1:0] sd);
		logic [3:0] e;
		unique case ({tri_idx, sd})
			3'b000: e = 4'b1001;
			3'b001: e = 4'b0001;
			3'b010: e = 4'b0010;
			3'b100: e = 4'b1001;
			3'b101: e = 4'b0111;
			3'b110: e = 4'b1011;
			default: e = 4'b0000;
		endcase
		return e;
	endfunction

endpackage

>>> hw/rtl/tcs_divider.sv
// Pipelined restoring divider: 32-bit numerator, 16-bit divisor, 16-bit quotient.
// Numerator must be below divisor * 2^16.
module tcs_divider (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic [15:0] quo,
	output logic        rem_nz
);

	logic [15:0] rem_s [tcs_pkg::DIV_STAGES];
	logic [15:0] low_s [tcs_pkg::DIV_STAGES];
	logic [15:0] quo_s [tcs_pkg::DIV_STAGES];
	logic [15:0] den_s [tcs_pkg::DIV_STAGES];

	logic [15:0] rem_n [tcs_pkg::DIV_STAGES];
	logic [15:0] low_n [tcs_pkg::DIV_STAGES];
	logic [15:0] quo_n [tcs_pkg::DIV_STAGES];
	logic [15:0] den_n [tcs_pkg::DIV_STAGES];

	// Each stage retires DIV_STEPS quotient bits
	always_comb begin
		logic [15:0] r;
		logic [15:0] l;
		logic [15:0] q;
		logic [15:0] d;
		logic [16:0] t;
		for (int k = 0; k < tcs_pkg::DIV_STAGES; k++) begin
			if (k == 0) begin
				r = num[31:16];
				l = num[15:0];
				q = '0;
				d = den;
			end else begin
				r = rem_s[k-1];
				l = low_s[k-1];
				q = quo_s[k-1];
				d = den_s[k-1];
			end
			for (int s = 0; s < tcs_pkg::DIV_STEPS; s++) begin
				t = {r, l[15]};
				l = {l[14:0], 1'b0};
				if (t >= {1'b0, d}) begin
					r = 16'(t - {1'b0, d});
					q = {q[14:0], 1'b1};
				end else begin
					r = t[15:0];
					q = {q[14:0], 1'b0};
				end
			end
			rem_n[k] = r;
			low_n[k] = l;
			quo_n[k] = q;
			den_n[k] = d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_n;
			low_s <= low_n;
			quo_s <= quo_n;
			den_s <= den_n;
		end
	end

	assign quo    = quo_s[tcs_pkg::DIV_STAGES-1];
	assign rem_nz = |rem_s[tcs_pkg::DIV_STAGES-1];

endmodule

>>> hw/rtl/triangle_contour_segments.sv
// Marching-triangles contour segment generator. Each accepted cell is split into two
// triangles and one (triangle, level) job is issued per cycle while the output is not
// stalled, so a cell holds the input until its 2*num_levels jobs are issued (one job when
// no level is active; num_levels is clamped to 4); the job sequencer issues the jobs.
// Jobs run through a nine-stage pipeline (job issue, crossing select, multiply, a four-stage
// divider for the interpolation, rounding, offset and saturation), then one holding
// register that resolves last_segment, then the output register; a segment waits in the
// holding register until the next segment or the end of its cell is seen. Up to one
// segment per cycle leaves while the output is not stalled.
// Configuration writes are always taken and must only happen while the block is idle.
module triangle_contour_segments (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         cell_row,
	input  logic [7:0]         cell_col,
	input  logic [7:0]         z_base,
	input  logic [7:0]         z_right,
	input  logic [7:0]         z_up,
	input  logic [7:0]         z_diag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         level_index,
	output logic               triangle_index,
	output logic signed [15:0] x_start,
	output logic signed [15:0] y_start,
	output logic signed [15:0] x_end,
	output logic signed [15:0] y_end,
	output logic               last_segment,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// Configuration registers
	logic [15:0]        level_q [tcs_pkg::MAX_LEVELS];
	logic [2:0]         num_levels_q;
	logic [15:0]        grid_scale_q;
	logic signed [15:0] x_offset_q;
	logic signed [15:0] y_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tcs_pkg::MAX_LEVELS; i++) level_q[i] <= '0;
			num_levels_q <= '0;
			grid_scale_q <= 16'd256;
			x_offset_q   <= '0;
			y_offset_q   <= '0;
		end else if (cfg_valid) begin
			unique case (tcs_pkg::reg_idx_t'(cfg_index))
				tcs_pkg::REG_LEVEL_0:    level_q[0]   <= cfg_data;
				tcs_pkg::REG_LEVEL_1:    level_q[1]   <= cfg_data;
				tcs_pkg::REG_LEVEL_2:    level_q[2]   <= cfg_data;
				tcs_pkg::REG_LEVEL_3:    level_q[3]   <= cfg_data;
				tcs_pkg::REG_NUM_LEVELS: num_levels_q <= cfg_data[2:0];
				tcs_pkg::REG_GRID_SCALE: grid_scale_q <= cfg_data;
				tcs_pkg::REG_X_OFFSET:   x_offset_q   <= cfg_data;
				tcs_pkg::REG_Y_OFFSET:   y_offset_q   <= cfg_data;
			endcase
		end
	end

	// Pipeline advances whenever the output register can take a transaction
	logic out_valid_q;
	logic adv;
	assign adv = !out_valid_q || !out_stall;

	// Job sequencer
	logic       busy_q;
	logic       tri_q;
	logic [1:0] lv_q;
	logic [7:0] row_q, col_q, zb_q, zr_q, zu_q, zd_q;
	logic [2:0] act;
	logic       last_job;
	logic       lv_end;
	logic       issue;
	logic       accept;

	assign act      = (num_levels_q > 3'(tcs_pkg::MAX_LEVELS)) ?
	                  3'(tcs_pkg::MAX_LEVELS) : num_levels_q;
	assign lv_end   = ({1'b0, lv_q} == act - 3'd1);
	assign last_job = (act == 3'd0) || (tri_q && lv_end);
	assign issue    = busy_q && adv;
	assign in_stall = busy_q && !(adv && last_job);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tri_q  <= 1'b0;
			lv_q   <= '0;
		end else if (issue && last_job) begin
			busy_q <= in_valid;
			tri_q  <= 1'b0;
			lv_q   <= '0;
		end else if (!busy_q) begin
			busy_q <= in_valid;
		end else if (issue) begin
			if (lv_end) begin
				tri_q <= 1'b1;
				lv_q  <= '0;
			end else begin
				lv_q <= lv_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= cell_row;
			col_q <= cell_col;
			zb_q  <= z_base;
			zr_q  <= z_right;
			zu_q  <= z_up;
			zd_q  <= z_diag;
		end
	end

	// Stage 1: issued job
	logic       v_s1, tri_s1, eoc_s1, empty_s1;
	logic [1:0] lv_s1;
	logic [7:0] row_s1, col_s1, zb_s1, zr_s1, zu_s1, zd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s1   <= tri_q;
			lv_s1    <= lv_q;
			eoc_s1   <= last_job;
			empty_s1 <= (act == 3'd0);
			row_s1   <= row_q;
			col_s1   <= col_q;
			zb_s1    <= zb_q;
			zr_s1    <= zr_q;
			zu_s1    <= zu_q;
			zd_s1    <= zd_q;
		end
	end

	// Crossing test on the three sides, pick the first two crossings
	function automatic logic [7:0] zsel(input logic [1:0] p, input logic [7:0] zb,
		input logic [7:0] zr, input logic [7:0] zu, input logic [7:0] zd);
		logic [7:0] z;
		unique case (p)
			2'b00: z = zb;
			2'b01: z = zr;
			2'b10: z = zu;
			2'b11: z = zd;
		endcase
		return z;
	endfunction

	logic [15:0] lvl_c;
	logic [2:0]  cross_c;
	logic [15:0] num_c [3];
	logic [15:0] den_c [3];
	logic [3:0]  ends_c [3];
	logic [1:0]  first_c, second_c;
	logic        hits2_c;

	assign lvl_c = level_q[lv_s1];

	always_comb begin
		logic [7:0] z1;
		logic [7:0] z2;
		logic       b1;
		logic       b2;
		for (int sd = 0; sd < 3; sd++) begin
			ends_c[sd] = tcs_pkg::side_ends(tri_s1, 2'(sd));
			z1 = zsel(ends_c[sd][3:2], zb_s1, zr_s1, zu_s1, zd_s1);
			z2 = zsel(ends_c[sd][1:0], zb_s1, zr_s1, zu_s1, zd_s1);
			b1 = {z1, 8'h00} < lvl_c;
			b2 = {z2, 8'h00} < lvl_c;
			cross_c[sd] = b1 ^ b2;
			if (z1 < z2) begin
				num_c[sd] = lvl_c - {z1, 8'h00};
				den_c[sd] = {8'(z2 - z1), 8'h00};
			end else begin
				num_c[sd] = {z1, 8'h00} - lvl_c;
				den_c[sd] = {8'(z1 - z2), 8'h00};
			end
		end
		first_c  = cross_c[0] ? 2'd0 : (cross_c[1] ? 2'd1 : 2'd2);
		second_c = (cross_c[0] && cross_c[1]) ? 2'd1 : 2'd2;
		hits2_c  = !empty_s1 && ((cross_c[0] && cross_c[1]) || (cross_c[0] && cross_c[2]) ||
		                         (cross_c[1] && cross_c[2]));
	end

	// Stage 2: crossing parameters
	logic        v_s2, tri_s2, eoc_s2, hits2_s2;
	logic [1:0]  lv_s2;
	logic [7:0]  row_s2, col_s2;
	logic [15:0] num0_s2, den0_s2, num1_s2, den1_s2;
	logic [3:0]  ends0_s2, ends1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s2   <= tri_s1;
			lv_s2    <= lv_s1;
			eoc_s2   <= eoc_s1;
			hits2_s2 <= hits2_c;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			num0_s2  <= num_c[first_c];
			den0_s2  <= den_c[first_c];
			ends0_s2 <= ends_c[first_c];
			num1_s2  <= num_c[second_c];
			den1_s2  <= den_c[second_c];
			ends1_s2 <= ends_c[second_c];
		end
	end

	// Stage 3: scale products
	logic                 v_s3;
	tcs_pkg::meta_t       meta_s3;
	logic [31:0]          p0_s3, p1_s3;
	logic [15:0]          den0_s3, den1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3.tri_idx <= tri_s2;
			meta_s3.lv      <= lv_s2;
			meta_s3.eoc     <= eoc_s2;
			meta_s3.hits2   <= hits2_s2;
			meta_s3.ends0   <= ends0_s2;
			meta_s3.ends1   <= ends1_s2;
			meta_s3.sc      <= 24'(grid_scale_q) * 24'(col_s2);
			meta_s3.sr      <= 24'(grid_scale_q) * 24'(row_s2);
			p0_s3           <= 32'(grid_scale_q) * 32'(num0_s2);
			p1_s3           <= 32'(grid_scale_q) * 32'(num1_s2);
			den0_s3         <= den0_s2;
			den1_s3         <= den1_s2;
		end
	end

	// Stages 4..7: interpolation fractions
	logic [15:0] quo0, quo1;
	logic        rnz0, rnz1;

	tcs_divider u_div0 (
		.clk    (clk),
		.en     (adv),
		.num    (p0_s3),
		.den    (den0_s3),
		.quo    (quo0),
		.rem_nz (rnz0)
	);

	tcs_divider u_div1 (
		.clk    (clk),
		.en     (adv),
		.num    (p1_s3),
		.den    (den1_s3),
		.quo    (quo1),
		.rem_nz (rnz1)
	);

	logic           v_s4, v_s5, v_s6, v_s7;
	tcs_pkg::meta_t meta_s4, meta_s5, meta_s6, meta_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
		end
	end

	// Rounded position in 8.8 units plus one half; floor of a descending step
	// drops one when the fraction is inexact
	function automatic logic [25:0] acc_calc(input logic [23:0] bprod, input logic add_s,
		input logic [15:0] s, input logic e_from, input logic e_to, input logic [15:0] q,
		input logic rnz);
		logic [25:0] a;
		a = 26'(bprod) + (add_s ? 26'(s) : 26'd0) + 26'd128;
		if (e_to && !e_from) a = a + 26'(q);
		else if (e_from && !e_to) a = a - 26'(q) - 26'(rnz);
		return a;
	endfunction

	// Stage 8: accumulated coordinates
	logic        v_s8, tri_s8, eoc_s8, hits2_s8;
	logic [1:0]  lv_s8;
	logic [25:0] ax0_s8, ay0_s8, ax1_s8, ay1_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s8   <= meta_s7.tri_idx;
			lv_s8    <= meta_s7.lv;
			eoc_s8   <= meta_s7.eoc;
			hits2_s8 <= meta_s7.hits2;
			ax0_s8   <= acc_calc(meta_s7.sc, meta_s7.ends0[2], grid_scale_q,
			                     meta_s7.ends0[2], meta_s7.ends0[0], quo0, rnz0);
			ay0_s8   <= acc_calc(meta_s7.sr, meta_s7.ends0[3], grid_scale_q,
			                     meta_s7.ends0[3], meta_s7.ends0[1], quo0, rnz0);
			ax1_s8   <= acc_calc(meta_s7.sc, meta_s7.ends1[2], grid_scale_q,
			                     meta_s7.ends1[2], meta_s7.ends1[0], quo1, rnz1);
			ay1_s8   <= acc_calc(meta_s7.sr, meta_s7.ends1[3], grid_scale_q,
			                     meta_s7.ends1[3], meta_s7.ends1[1], quo1, rnz1);
		end
	end

	// Add origin and clamp to signed 16 bits
	function automatic logic signed [15:0] sat_coord(input logic signed [15:0] off,
		input logic [25:0] acc);
		logic signed [18:0] sum;
		sum = 19'(off) + $signed({2'b00, acc[24:8]});
		if (sum > 19'sd32767) return 16'sh7fff;
		else if (sum < -19'sd32768) return 16'sh8000;
		else return sum[15:0];
	endfunction

	logic signed [15:0] x0_c, y0_c, x1_c, y1_c;

	assign x0_c = sat_coord(x_offset_q, ax0_s8);
	assign y0_c = sat_coord(y_offset_q, ay0_s8);
	assign x1_c = sat_coord(x_offset_q, ax1_s8);
	assign y1_c = sat_coord(y_offset_q, ay1_s8);

	// Stage 9: final segment
	logic               v_s9, tri_s9, eoc_s9, seg_s9;
	logic [1:0]         lv_s9;
	logic signed [15:0] x0_s9, y0_s9, x1_s9, y1_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s9 <= tri_s8;
			lv_s9  <= lv_s8;
			eoc_s9 <= eoc_s8;
			seg_s9 <= hits2_s8 && ((x0_c != x1_c) || (y0_c != y1_c));
			x0_s9  <= x0_c;
			y0_s9  <= y0_c;
			x1_s9  <= x1_c;
			y1_s9  <= y1_c;
		end
	end

	// Holding register: a segment leaves once the next one or the end of its cell is seen
	logic               pend_valid_q, pend_final_q;
	logic               pend_tri_q;
	logic [1:0]         pend_lv_q;
	logic signed [15:0] pend_x0_q, pend_y0_q, pend_x1_q, pend_y1_q;
	logic               j_seg, j_eoc;
	logic               flush_final, flush_next, flush_end, load_out;

	assign j_seg       = v_s9 && seg_s9;
	assign j_eoc       = v_s9 && eoc_s9;
	assign flush_final = pend_valid_q && pend_final_q;
	assign flush_next  = pend_valid_q && !pend_final_q && j_seg;
	assign flush_end   = pend_valid_q && !pend_final_q && !j_seg && j_eoc;
	assign load_out    = flush_final || flush_next || flush_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_final_q <= 1'b0;
		end else if (adv) begin
			if (j_seg) begin
				pend_valid_q <= 1'b1;
				pend_final_q <= eoc_s9;
			end else if (load_out) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && j_seg) begin
			pend_tri_q <= tri_s9;
			pend_lv_q  <= lv_s9;
			pend_x0_q  <= x0_s9;
			pend_y0_q  <= y0_s9;
			pend_x1_q  <= x1_s9;
			pend_y1_q  <= y1_s9;
		end
	end

	// Output register
	logic               out_tri_q, out_last_q;
	logic [1:0]         out_lv_q;
	logic signed [15:0] out_x0_q, out_y0_q, out_x1_q, out_y1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= load_out;
	end

	always_ff @(posedge clk) begin
		if (adv && load_out) begin
			out_tri_q  <= pend_tri_q;
			out_lv_q   <= pend_lv_q;
			out_x0_q   <= pend_x0_q;
			out_y0_q   <= pend_y0_q;
			out_x1_q   <= pend_x1_q;
			out_y1_q   <= pend_y1_q;
			out_last_q <= flush_final || flush_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign level_index    = out_lv_q;
	assign triangle_index = out_tri_q;
	assign x_start        = out_x0_q;
	assign y_start        = out_y0_q;
	assign x_end          = out_x1_q;
	assign y_end          = out_y1_q;
	assign last_segment   = out_last_q;

endmodule

>>> hw/rtl/tcs_checker.sv
`include "triangle_contour_segments_assert.svh"

// Port-level checks for the contour segment block
module tcs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         cell_row,
	input logic [7:0]         cell_col,
	input logic [7:0]         z_base,
	input logic [7:0]         z_right,
	input logic [7:0]         z_up,
	input logic [7:0]         z_diag,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         level_index,
	input logic               triangle_index,
	input logic signed [15:0] x_start,
	input logic signed [15:0] y_start,
	input logic signed [15:0] x_end,
	input logic signed [15:0] y_end,
	input logic               last_segment,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// A stalled cell transaction stays put
	`TCS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable({cell_row, cell_col, z_base, z_right, z_up, z_diag}), "stalled input changed")

	// A stalled transaction stays put
	`TCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({level_index, triangle_index, x_start, y_start, x_end, y_end, last_segment}), "stalled output changed")

	// Degenerate segments are never emitted
	`TCS_ASSERT_NOW(a_seg_len, out_valid, (x_start != x_end) || (y_start != y_end), "zero-length segment")

	// Register writes are never back-pressured
	`TCS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind triangle_contour_segments tcs_checker u_tcs_checker (.*);
